// File: rtl/fbla_pkg.sv
// Package: shared constants, codes and beat types of the fixed block LIFO allocator.
package fbla_pkg;

  localparam int unsigned BLOCK_BYTES = 32;
  localparam int unsigned NUM_BLOCKS  = 8;
  localparam int unsigned IDX_W       = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int unsigned LINK_W      = IDX_W + 1;
  localparam int unsigned BLK_SHIFT   = $clog2(BLOCK_BYTES);
  localparam int unsigned POOL_BYTES  = NUM_BLOCKS * BLOCK_BYTES;
  localparam int unsigned CQ_DEPTH    = 2;
  localparam int unsigned CQ_PTR_W    = $clog2(CQ_DEPTH);
  localparam int unsigned CQ_CNT_W    = $clog2(CQ_DEPTH + 1);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_NOMEM  = 3'd1;
  localparam logic [2:0] ST_TOOBIG = 3'd2;
  localparam logic [2:0] ST_BADPTR = 3'd3;
  localparam logic [2:0] ST_DOUBLE = 3'd4;

  typedef struct packed {
    logic        operation;
    logic [15:0] request_bytes;
    logic        pointer_is_null;
    logic [9:0]  block_offset;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] granted_offset;
  } rsp_t;

  // Classified command passed from front to back.
  typedef struct packed {
    logic             is_free;
    logic             too_big;
    logic             bad_ptr;
    logic [IDX_W-1:0] blk;
  } cmd_t;

endpackage

// File: rtl/fbla_front.sv
// Front end: decodes a request beat and runs the state-independent checks.
module fbla_front import fbla_pkg::*; (
  input  req_t req_i,
  output cmd_t cmd_o
);

  localparam logic [10:0] PoolBytes = 11'(POOL_BYTES);
  localparam logic [16:0] BlkBytes  = 17'(BLOCK_BYTES);

  logic [IDX_W-1:0] shifted;
  logic             misaligned;

  assign shifted    = IDX_W'(req_i.block_offset >> BLK_SHIFT);
  assign misaligned = (req_i.block_offset & 10'(BLOCK_BYTES - 1)) != 10'd0;

  always_comb begin
    cmd_o.is_free = (req_i.operation == OP_FREE);
    cmd_o.too_big = {1'b0, req_i.request_bytes} > BlkBytes;
    cmd_o.bad_ptr = req_i.pointer_is_null | ({1'b0, req_i.block_offset} >= PoolBytes)
                    | misaligned;
    cmd_o.blk     = shifted;
  end

endmodule

// File: rtl/fbla_cmd_fifo.sv
// Short command queue between front and back.
module fbla_cmd_fifo import fbla_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  cmd_t wr_data_i,
  output logic full_o,
  input  logic rd_i,
  output logic valid_o,
  output cmd_t rd_data_o
);

  cmd_t                mem_q [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CQ_CNT_W-1:0] cnt_q, cnt_d;
  logic                do_wr, do_rd;

  assign full_o    = (cnt_q == CQ_CNT_W'(CQ_DEPTH));
  assign valid_o   = (cnt_q != '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_i & ~full_o;
  assign do_rd     = rd_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CQ_CNT_W'(CQ_DEPTH))
    else $error("command queue count out of range");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_wr && !do_rd) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("command queue count missed a write");

endmodule

// File: rtl/fbla_back.sv
// Back end: free list, used marks and the result register.
module fbla_back import fbla_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_rd_o,
  output logic rsp_valid_o,
  output rsp_t rsp_o,
  input  logic rsp_pop_i
);

  logic [LINK_W-1:0]     link_q [NUM_BLOCKS];
  logic [IDX_W-1:0]      head_q, head_d;
  logic                  empty_q, empty_d;
  logic [NUM_BLOCKS-1:0] used_q, used_d;
  logic                  out_vld_q;
  rsp_t                  out_q, out_d;
  logic                  adv;
  logic                  do_push;
  logic [LINK_W-1:0]     nxt;
  logic                  nxt_end;

  assign adv         = cmd_valid_i & (~out_vld_q | rsp_pop_i);
  assign cmd_rd_o    = adv;
  assign rsp_valid_o = out_vld_q;
  assign rsp_o       = out_q;
  assign nxt         = link_q[head_q];
  assign nxt_end     = (nxt >= LINK_W'(NUM_BLOCKS)) || (nxt[IDX_W-1:0] == head_q)
                       || used_q[nxt[IDX_W-1:0]];

  always_comb begin
    head_d  = head_q;
    empty_d = empty_q;
    used_d  = used_q;
    do_push = 1'b0;
    out_d   = '{status: ST_OK, granted_offset: 8'd0};
    if (!cmd_i.is_free) begin
      if (empty_q) begin
        out_d.status = ST_NOMEM;
      end else if (cmd_i.too_big) begin
        out_d.status = ST_TOOBIG;
      end else begin
        used_d[head_q]       = 1'b1;
        out_d.granted_offset = 8'(({{(32-IDX_W){1'b0}}, head_q}) << BLK_SHIFT);
        if (nxt_end) begin
          empty_d = 1'b1;
        end else begin
          head_d = nxt[IDX_W-1:0];
        end
      end
    end else begin
      if (cmd_i.bad_ptr) begin
        out_d.status = ST_BADPTR;
      end else if (!used_q[cmd_i.blk]) begin
        out_d.status = ST_DOUBLE;
      end else begin
        used_d[cmd_i.blk] = 1'b0;
        head_d            = cmd_i.blk;
        empty_d           = 1'b0;
        do_push           = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BLOCKS; i++) begin
        link_q[i] <= LINK_W'(i + 1);
      end
      head_q    <= '0;
      empty_q   <= 1'b0;
      used_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv) begin
        head_q  <= head_d;
        empty_q <= empty_d;
        used_q  <= used_d;
        if (do_push) begin
          link_q[cmd_i.blk] <= {1'b0, head_q};
        end
        out_vld_q <= 1'b1;
      end else if (rsp_pop_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  a_head_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_q |-> !used_q[head_q])
    else $error("free list head is marked used");

  a_empty_all_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_q |-> (used_q == '1))
    else $error("list empty while a block is free");

  a_err_zero_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.status != ST_OK) |-> (out_q.granted_offset == 8'd0))
    else $error("failed beat carries an offset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !rsp_pop_i) |=> (out_vld_q && $stable(out_q)))
    else $error("pending result changed before pop");

endmodule

// File: rtl/fixed_block_lifo_allocator.sv
// Top level: fixed-size block allocator with a LIFO free list.
//
//   channel   ports                      beat
//   request   push, full, in_item_i      req_t   (operation, size, pointer)
//   result    empty, pop, out_item_o     rsp_t   (status, granted offset)
//
// One beat per cycle sustained while results are popped; an accepted request is written into
// the command queue (front classifies), then the back end updates the result register.
// Reset loads the free list 0..NUM_BLOCKS-1 while rst_ni is low, head at block 0.
// The two-entry command queue lets requests be taken while a result waits;
// full rises once it fills behind a stalled result.
module fixed_block_lifo_allocator import fbla_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push,
  output logic full,
  input  req_t in_item_i,
  output logic empty,
  input  logic pop,
  output rsp_t out_item_o
);

  cmd_t cmd_in, cmd_out;
  logic cq_valid, cq_rd, rsp_valid;

  fbla_front u_front (
    .req_i (in_item_i),
    .cmd_o (cmd_in)
  );

  fbla_cmd_fifo u_cmd_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (push),
    .wr_data_i (cmd_in),
    .full_o    (full),
    .rd_i      (cq_rd),
    .valid_o   (cq_valid),
    .rd_data_o (cmd_out)
  );

  fbla_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cq_valid),
    .cmd_i       (cmd_out),
    .cmd_rd_o    (cq_rd),
    .rsp_valid_o (rsp_valid),
    .rsp_o       (out_item_o),
    .rsp_pop_i   (pop)
  );

  assign empty = ~rsp_valid;

endmodule

// File: tb/sv/fbla_checker.sv
// Checker: tracks the allocator's free list from accepted requests and compares every result beat.
`timescale 1ns / 100ps

module fbla_checker import fbla_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  req_t        req_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  rsp_t        rsp_i,
  output int unsigned fail_cnt_o,
  output int unsigned outstanding_o,
  output int unsigned checked_o,
  output int unsigned grants_o,
  output int unsigned releases_o,
  output int unsigned nomem_o,
  output int unsigned rejects_o
);

  logic [LINK_W-1:0] next_link [NUM_BLOCKS];
  logic              in_use    [NUM_BLOCKS];
  logic [IDX_W-1:0]  head_blk;
  logic              pool_exhausted;

  rsp_t pending_replies [$];
  rsp_t want;
  rsp_t predicted;

  int unsigned fail_cnt = 0;
  int unsigned checked = 0;
  int unsigned grants = 0;
  int unsigned releases = 0;
  int unsigned nomem = 0;
  int unsigned rejects = 0;
  int unsigned outstanding = 0;

  assign fail_cnt_o    = fail_cnt;
  assign outstanding_o = outstanding;
  assign checked_o     = checked;
  assign grants_o      = grants;
  assign releases_o    = releases;
  assign nomem_o       = nomem;
  assign rejects_o     = rejects;

  // Applies one request to the tracked free list and returns the reply it must produce.
  function automatic rsp_t serve_request(input req_t r);
    rsp_t        rsp;
    int unsigned blk;
    int unsigned nxt;
    rsp = '0;
    rsp.status = ST_OK;
    if (r.operation == OP_ALLOC) begin
      if (pool_exhausted) begin
        rsp.status = ST_NOMEM;
      end else if (r.request_bytes > BLOCK_BYTES) begin
        rsp.status = ST_TOOBIG;
      end else begin
        blk = head_blk;
        in_use[blk] = 1'b1;
        nxt = next_link[blk];
        // tail reached: link runs off the pool or into a block already handed out
        if (nxt >= NUM_BLOCKS || in_use[nxt]) begin
          pool_exhausted = 1'b1;
        end else begin
          head_blk = IDX_W'(nxt);
        end
        rsp.granted_offset = 8'(blk * BLOCK_BYTES);
      end
    end else begin
      if (r.pointer_is_null || (r.block_offset >= POOL_BYTES) ||
          ((r.block_offset % BLOCK_BYTES) != 0)) begin
        rsp.status = ST_BADPTR;
      end else begin
        blk = r.block_offset / BLOCK_BYTES;
        if (!in_use[blk]) begin
          rsp.status = ST_DOUBLE;
        end else begin
          in_use[blk] = 1'b0;
          next_link[blk] = LINK_W'(head_blk);
          head_blk = IDX_W'(blk);
          pool_exhausted = 1'b0;
        end
      end
    end
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BLOCKS; i++) begin
        next_link[i] = LINK_W'(i + 1);
        in_use[i] = 1'b0;
      end
      head_blk = '0;
      pool_exhausted = 1'b0;
      pending_replies.delete();
      outstanding = 0;
    end else begin
      if (pop_i && !empty_i) begin
        if (pending_replies.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected result beat: status %0d offset %0d", $time,
                   rsp_i.status, rsp_i.granted_offset);
        end else begin
          want = pending_replies.pop_front();
          checked++;
          if (rsp_i.status !== want.status) begin
            fail_cnt++;
            $display("%0t: status expected %0d actual %0d", $time,
                     want.status, rsp_i.status);
          end
          if (rsp_i.granted_offset !== want.granted_offset) begin
            fail_cnt++;
            $display("%0t: granted_offset expected %0d actual %0d", $time,
                     want.granted_offset, rsp_i.granted_offset);
          end
        end
      end
      if (push_i && !full_i) begin
        predicted = serve_request(req_i);
        pending_replies.push_back(predicted);
        if (predicted.status == ST_OK && req_i.operation == OP_ALLOC) begin
          grants++;
        end else if (predicted.status == ST_OK) begin
          releases++;
        end else if (predicted.status == ST_NOMEM) begin
          nomem++;
        end else begin
          rejects++;
        end
      end
      outstanding = pending_replies.size();
    end
  end

endmodule

// File: tb/sv/tb_top.sv
// Testbench top: drives allocate/free requests and result pops with random gaps, gives the verdict.
`timescale 1ns / 100ps

module tb_top;
  import fbla_pkg::*;

  localparam int unsigned SEGMENTS     = 12;
  localparam int unsigned SEG_ITEMS    = 50;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned HOLD_AT_BEAT = 120;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  req_t req_beat = '0;
  logic full;
  logic empty;
  rsp_t rsp_beat;

  int unsigned fail_cnt;
  int unsigned outstanding;
  int unsigned checked;
  int unsigned grants;
  int unsigned releases;
  int unsigned nomem;
  int unsigned rejects;

  int unsigned send_burst = 0;
  int unsigned recv_burst = 0;
  int unsigned stall_cycles = 0;

  always #5 clk = ~clk;

  fixed_block_lifo_allocator dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .push       (push),
    .full       (full),
    .in_item_i  (req_beat),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (rsp_beat)
  );

  fbla_checker u_lifo_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .push_i        (push),
    .full_i        (full),
    .req_i         (req_beat),
    .empty_i       (empty),
    .pop_i         (pop),
    .rsp_i         (rsp_beat),
    .fail_cnt_o    (fail_cnt),
    .outstanding_o (outstanding),
    .checked_o     (checked),
    .grants_o      (grants),
    .releases_o    (releases),
    .nomem_o       (nomem),
    .rejects_o     (rejects)
  );

  always @(posedge clk) begin
    if (push && full) begin
      stall_cycles++;
    end
  end

  initial begin
    #5ms;
    $display("fixed_block_lifo_allocator: mismatch");
    $finish;
  end

  // Mostly short gaps, a few long ones, and occasional runs with none.
  function automatic int unsigned pick_gap(inout int unsigned burst);
    int unsigned r;
    if (burst != 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      burst = $urandom_range(20, 60);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic req_t alloc_req(input int unsigned size);
    req_t r;
    r.operation = OP_ALLOC;
    r.request_bytes = 16'(size);
    r.pointer_is_null = 1'($urandom);
    r.block_offset = 10'($urandom);
    return r;
  endfunction

  function automatic req_t free_req(input logic is_null, input int unsigned offset);
    req_t r;
    r.operation = OP_FREE;
    r.request_bytes = 16'($urandom);
    r.pointer_is_null = is_null;
    r.block_offset = 10'(offset);
    return r;
  endfunction

  function automatic req_t random_req(input int unsigned alloc_pct);
    int unsigned k;
    k = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < alloc_pct) begin
      if (k < 80) return alloc_req($urandom_range(0, BLOCK_BYTES));
      if (k < 90) return alloc_req($urandom_range(BLOCK_BYTES + 1, 2 * BLOCK_BYTES));
      return alloc_req(16'($urandom));
    end
    if (k < 80) return free_req(1'b0, $urandom_range(0, NUM_BLOCKS - 1) * BLOCK_BYTES);
    if (k < 88) return free_req(1'b1, 10'($urandom));
    return free_req(1'($urandom), 10'($urandom));
  endfunction

  task automatic offer(input req_t r);
    int unsigned gap;
    gap = pick_gap(send_burst);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    req_beat <= r;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Result side; one long hold-off lets the block fill and push back on the input.
  initial begin
    int unsigned gap;
    int unsigned taken;
    logic        held;
    taken = 0;
    held = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (taken == HOLD_AT_BEAT && !held) begin
        held = 1'b1;
        pop <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      gap = pick_gap(recv_burst);
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      taken++;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    offer(alloc_req(0));
    offer(alloc_req(BLOCK_BYTES));
    offer(alloc_req(BLOCK_BYTES + 1));
    offer(alloc_req(16'hFFFF));
    offer(free_req(1'b1, 0));
    offer(free_req(1'b0, POOL_BYTES));
    offer(free_req(1'b0, 10'h3FF));
    offer(free_req(1'b0, 17));
    offer(free_req(1'b0, 3 * BLOCK_BYTES));
    offer(free_req(1'b0, 0));
    offer(free_req(1'b0, 0));
    offer(free_req(1'b0, BLOCK_BYTES));
    // drain the whole pool, then hit the empty list with both sizes
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      offer(alloc_req($urandom_range(0, BLOCK_BYTES)));
    end
    offer(alloc_req(16'hFFFF));
    offer(alloc_req(0));
    offer(free_req(1'b0, (NUM_BLOCKS - 1) * BLOCK_BYTES));
    offer(alloc_req(BLOCK_BYTES));
    offer(free_req(1'b0, (NUM_BLOCKS - 1) * BLOCK_BYTES));

    for (int s = 0; s < SEGMENTS; s++) begin
      for (int n = 0; n < SEG_ITEMS; n++) begin
        offer(random_req((s % 3 == 0) ? 85 : (s % 3 == 1) ? 15 : 50));
      end
    end
    push <= 1'b0;

    do @(negedge clk); while (outstanding != 0);
    repeat (6) @(posedge clk);

    $display("checked %0d results: %0d grants, %0d releases, %0d out of memory, %0d rejected",
             checked, grants, releases, nomem, rejects);
    $display("request side held off by full for %0d cycles", stall_cycles);
    if (fail_cnt == 0 && outstanding == 0) begin
      $display("fixed_block_lifo_allocator: match");
    end else begin
      $display("fixed_block_lifo_allocator: mismatch");
    end
    $finish;
  end

endmodule
